// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the broadcast ring buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/brbo_pkg.sv
// Types, codes and constants shared by the broadcast ring buffer modules.
package brbo_pkg;

  localparam int BUFFER_DEPTH_DEF = 1024;
  localparam int MAX_READERS_DEF  = 8;
  localparam int MAX_BURST_DEF    = 16;

  localparam int COUNT_W = 32;
  // Wide enough for any burst limit the block supports.
  localparam int WANT_W  = 7;

  localparam int Q_DEPTH = 2;
  localparam int QPW     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW     = $clog2(Q_DEPTH + 1);

  // Request command codes.
  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_OPEN    = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_CLOSE   = 3'd4;

  // Result status codes.
  localparam logic [2:0] STAT_DATA    = 3'd0;
  localparam logic [2:0] STAT_EMPTY   = 3'd1;
  localparam logic [2:0] STAT_INVALID = 3'd2;
  localparam logic [2:0] STAT_NOSLOT  = 3'd3;
  localparam logic [2:0] STAT_OK      = 3'd4;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [2:0] reader_id;
    logic [4:0] max_count;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [2:0] slot_given;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_OPEN,
    OP_RELEASE,
    OP_CLOSE
  } op_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_t               op;
    logic [7:0]        data;
    logic [2:0]        id;
    logic              id_ok;
    logic [WANT_W-1:0] want;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR_FIX,
    ST_ADDR_WRAP,
    ST_FETCH,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/brbo_front.sv
// Front end: takes requests, decodes and checks them, and queues them.
module brbo_front #(
  parameter int MAX_READERS = brbo_pkg::MAX_READERS_DEF,
  parameter int MAX_BURST   = brbo_pkg::MAX_BURST_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  brbo_pkg::req_t      req,
  input  brbo_pkg::q_status_t q_status,
  output logic                q_push,
  output brbo_pkg::cmd_t      q_entry
);

  logic known;

  assign req_ready = !q_status.full;

  always_comb begin
    known      = 1'b1;
    q_entry.op = brbo_pkg::OP_WRITE;
    unique case (req.command)
      brbo_pkg::CMD_WRITE:   q_entry.op = brbo_pkg::OP_WRITE;
      brbo_pkg::CMD_READ:    q_entry.op = brbo_pkg::OP_READ;
      brbo_pkg::CMD_OPEN:    q_entry.op = brbo_pkg::OP_OPEN;
      brbo_pkg::CMD_RELEASE: q_entry.op = brbo_pkg::OP_RELEASE;
      brbo_pkg::CMD_CLOSE:   q_entry.op = brbo_pkg::OP_CLOSE;
      default:               known = 1'b0;
    endcase
    q_entry.data  = req.data_byte;
    q_entry.id    = req.reader_id;
    q_entry.id_ok = (32'(req.reader_id) < 32'(MAX_READERS));
    // Bursts longer than the limit are cut to the limit.
    if (32'(req.max_count) > 32'(MAX_BURST)) begin
      q_entry.want = brbo_pkg::WANT_W'(MAX_BURST);
    end else begin
      q_entry.want = brbo_pkg::WANT_W'(req.max_count);
    end
  end

  // Unknown commands are taken and dropped here; they have no result.
  assign q_push = req_valid && req_ready && known;

  `include "assert_macros.svh"

  `ASSERT_IMPLY(a_front_drop_only_unknown, req_valid && req_ready && !q_push, req.command > brbo_pkg::CMD_CLOSE, "known request dropped")

endmodule

// File: rtl/core/brbo_queue.sv
// Short queue of decoded requests between the front and back ends.
module brbo_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  brbo_pkg::cmd_t      push_entry,
  input  logic                pop,
  output brbo_pkg::cmd_t      pop_entry,
  output brbo_pkg::q_status_t status
);

  brbo_pkg::cmd_t              entries [brbo_pkg::Q_DEPTH];
  logic [brbo_pkg::QPW-1:0]    wr_ptr;
  logic [brbo_pkg::QPW-1:0]    rd_ptr;
  logic [brbo_pkg::QCW-1:0]    count;

  assign status.empty = (count == '0);
  assign status.full  = (count == brbo_pkg::QCW'(brbo_pkg::Q_DEPTH));
  assign pop_entry    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == brbo_pkg::QPW'(brbo_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == brbo_pkg::QPW'(brbo_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_queue_no_underflow, !(pop && status.empty), "pop from an empty queue")
  `ASSERT_ALWAYS(a_queue_count_range, count <= brbo_pkg::QCW'(brbo_pkg::Q_DEPTH), "queue count out of range")

endmodule

// File: rtl/core/brbo_back.sv
// Back end: reader table, byte store, read burst sequencer and result register.
module brbo_back #(
  parameter int BUFFER_DEPTH = brbo_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_READERS  = brbo_pkg::MAX_READERS_DEF,
  parameter int MAX_BURST    = brbo_pkg::MAX_BURST_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  brbo_pkg::q_status_t q_status,
  input  brbo_pkg::cmd_t      q,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output brbo_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int LW = $clog2(BUFFER_DEPTH + 1);
  localparam int DW = LW + 1;
  localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam longint unsigned WRAP_K = 64'h1_0000_0000 % BUFFER_DEPTH;

  brbo_pkg::state_t state, state_next;

  logic [brbo_pkg::COUNT_W-1:0] head;
  logic [AW-1:0]                head_addr;
  logic [AW-1:0]                head_addr_next;
  logic                         accepting;
  logic [MAX_READERS-1:0]       active;
  // Lag of each reader behind the head; never above the buffer depth.
  logic [LW-1:0]                lag [MAX_READERS];

  logic [7:0]                   byte_store [BUFFER_DEPTH];
  logic [7:0]                   mem_q;
  logic                         mem_we;

  logic [RW-1:0]                idx;
  logic [LW-1:0]                lag_sel;
  logic                         slot_ok;
  logic [BW-1:0]                n;
  logic                         free_found;
  logic [RW-1:0]                free_idx;

  logic [BW-1:0]                cnt;
  logic [LW-1:0]                rem;
  logic [LW-1:0]                rem_step;
  logic [DW-1:0]                diff;
  logic                         wrap_flag;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                rd_addr_step;
  logic [AW:0]                  wrap_sum;

  logic                         out_free;
  logic                         load_out;
  logic                         start_read;
  brbo_pkg::rsp_t               rsp_next;

  assign out_free = !rsp_valid || rsp_ready;
  assign idx      = RW'(q.id);
  assign lag_sel  = lag[idx];
  assign slot_ok  = q.id_ok && active[idx];
  assign n        = (32'(q.want) < 32'(lag_sel)) ? BW'(q.want) : BW'(lag_sel);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_READERS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = RW'(i);
      end
    end
  end

  // Head index wraps at the depth, and restarts at zero when the count wraps.
  assign head_addr_next = (head == '1) ? '0 :
                          (head_addr == AW'(BUFFER_DEPTH - 1)) ? '0 : head_addr + 1'b1;

  assign rem_step = rem - 1'b1;
  assign rd_addr_step =
      ((head[brbo_pkg::COUNT_W-1:LW] == '0) && (head[LW-1:0] == rem_step)) ? '0 :
      (rd_addr == AW'(BUFFER_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
  assign wrap_sum = (AW+1)'(rd_addr) + (AW+1)'(WRAP_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brbo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    start_read = 1'b0;
    mem_we     = 1'b0;
    rsp_next   = '0;
    unique case (state)
      brbo_pkg::ST_IDLE: begin
        if (!q_status.empty && out_free) begin
          pop             = 1'b1;
          load_out        = 1'b1;
          rsp_next.status = brbo_pkg::STAT_OK;
          rsp_next.last   = 1'b1;
          unique case (q.op)
            brbo_pkg::OP_WRITE: begin
              mem_we = accepting;
            end
            brbo_pkg::OP_READ: begin
              if (!slot_ok) begin
                rsp_next.status = brbo_pkg::STAT_INVALID;
              end else if (n == '0) begin
                rsp_next.status = brbo_pkg::STAT_EMPTY;
              end else begin
                load_out   = 1'b0;
                start_read = 1'b1;
                state_next = brbo_pkg::ST_ADDR_FIX;
              end
            end
            brbo_pkg::OP_OPEN: begin
              if (free_found) begin
                rsp_next.slot_given = 3'(free_idx);
              end else begin
                rsp_next.status = brbo_pkg::STAT_NOSLOT;
              end
            end
            brbo_pkg::OP_RELEASE: begin
              if (!q.id_ok) begin
                rsp_next.status = brbo_pkg::STAT_INVALID;
              end
            end
            brbo_pkg::OP_CLOSE: begin
              rsp_next.status = brbo_pkg::STAT_OK;
            end
            default: begin
              load_out = 1'b0;
            end
          endcase
        end
      end
      brbo_pkg::ST_ADDR_FIX:  state_next = brbo_pkg::ST_ADDR_WRAP;
      brbo_pkg::ST_ADDR_WRAP: state_next = brbo_pkg::ST_FETCH;
      brbo_pkg::ST_FETCH:     state_next = brbo_pkg::ST_EMIT;
      brbo_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out          = 1'b1;
          rsp_next.out_byte = mem_q;
          rsp_next.status   = brbo_pkg::STAT_DATA;
          rsp_next.last     = (cnt == BW'(1));
          state_next        = (cnt == BW'(1)) ? brbo_pkg::ST_IDLE : brbo_pkg::ST_FETCH;
        end
      end
      default: state_next = brbo_pkg::ST_IDLE;
    endcase
  end

  // Writer and reader table control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      head_addr <= '0;
      accepting <= 1'b1;
      active    <= '0;
    end else if (pop) begin
      case (q.op)
        brbo_pkg::OP_WRITE: begin
          if (accepting) begin
            head      <= head + 1'b1;
            head_addr <= head_addr_next;
          end
        end
        brbo_pkg::OP_OPEN: begin
          if (free_found) begin
            active[free_idx] <= 1'b1;
          end
        end
        brbo_pkg::OP_RELEASE: begin
          if (q.id_ok) begin
            active[idx] <= 1'b0;
          end
        end
        brbo_pkg::OP_CLOSE: accepting <= 1'b0;
        default: ;
      endcase
    end
  end

  // A reader a full buffer behind is dragged along, so its lag stays at the depth.
  always_ff @(posedge clk) begin
    if (pop && (q.op == brbo_pkg::OP_WRITE) && accepting) begin
      for (int i = 0; i < MAX_READERS; i++) begin
        if (active[i] && (lag[i] != LW'(BUFFER_DEPTH))) begin
          lag[i] <= lag[i] + 1'b1;
        end
      end
    end else if (pop && (q.op == brbo_pkg::OP_OPEN) && free_found) begin
      lag[free_idx] <= '0;
    end else if (start_read) begin
      lag[idx] <= lag_sel - LW'(n);
    end
  end

  // Read burst sequencer: start index of the reader, then one byte per fetch.
  always_ff @(posedge clk) begin
    if (start_read) begin
      cnt       <= n;
      rem       <= lag_sel;
      diff      <= DW'(head_addr) - DW'(lag_sel);
      wrap_flag <= (head[brbo_pkg::COUNT_W-1:LW] == '0) && (head[LW-1:0] < lag_sel);
    end else if (state == brbo_pkg::ST_ADDR_FIX) begin
      rd_addr <= diff[DW-1] ? AW'(diff + DW'(BUFFER_DEPTH)) : AW'(diff);
    end else if (state == brbo_pkg::ST_ADDR_WRAP) begin
      // The reader's count lies before a wrap of the head count.
      if (wrap_flag) begin
        rd_addr <= (wrap_sum >= (AW+1)'(BUFFER_DEPTH)) ?
                   AW'(wrap_sum - (AW+1)'(BUFFER_DEPTH)) : AW'(wrap_sum);
      end
    end else if ((state == brbo_pkg::ST_EMIT) && out_free) begin
      cnt     <= cnt - 1'b1;
      rem     <= rem_step;
      rd_addr <= rd_addr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[head_addr] <= q.data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == brbo_pkg::ST_FETCH) begin
      mem_q <= byte_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= rsp_next;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_IMPLY(a_back_emit_count, state == brbo_pkg::ST_EMIT, cnt != '0, "burst with no bytes left")
  `ASSERT_ALWAYS(a_back_head_range, (AW+1)'(head_addr) < (AW+1)'(BUFFER_DEPTH), "head index past depth")
  `ASSERT_IMPLY(a_back_close_only, $fell(accepting), $past(pop) && ($past(q.op) == brbo_pkg::OP_CLOSE), "writes stopped without close")

endmodule

// File: rtl/core/broadcast_ring_buffer_overwrite.sv
// Top level of the multi-reader broadcast byte ring buffer with overwrite.
//
// One writer appends bytes to a ring of BUFFER_DEPTH entries and up to MAX_READERS
// reader slots each consume them at their own pace. Every request is a write, read,
// open, release or close, and each gives exactly one result, except that a read that
// finds data returns one result per byte (at most MAX_BURST) with last set on the
// final one; unknown command codes are taken and give no result. A writer never
// waits for slow readers: once a reader is a full buffer behind, every write drags
// it forward and its oldest byte is lost. Requests pass a front end that decodes and
// checks them into a two-entry queue; the back end owns the reader table, the byte
// store and the result register, so new requests are taken while a result waits.
// Write, open, release, close and failed or empty reads finish in the idle state
// of the back end. A read that returns data first forms the reader's start index
// (ST_ADDR_FIX, ST_ADDR_WRAP), then takes each byte through ST_FETCH and ST_EMIT,
// as it passes the store's single registered read port before the result register.
// The reset state is immediate; the byte store is not cleared and needs no sweep.
module broadcast_ring_buffer_overwrite #(
  parameter int BUFFER_DEPTH = brbo_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_READERS  = brbo_pkg::MAX_READERS_DEF,
  parameter int MAX_BURST    = brbo_pkg::MAX_BURST_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  brbo_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output brbo_pkg::rsp_t rsp
);

  brbo_pkg::q_status_t q_status;
  brbo_pkg::cmd_t      push_entry;
  brbo_pkg::cmd_t      pop_entry;
  logic                push;
  logic                pop;

  // Decode and check each request before it is queued.
  brbo_front #(
    .MAX_READERS (MAX_READERS),
    .MAX_BURST   (MAX_BURST)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_status  (q_status),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  // The queue lets the front keep taking requests while a read burst drains.
  brbo_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  // All buffer state lives in the back end, which runs one request at a time.
  brbo_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_READERS  (MAX_READERS),
    .MAX_BURST    (MAX_BURST)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q         (pop_entry),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: sim/tb_broadcast_ring_buffer_overwrite.sv
// Self-checking testbench for the multi-reader broadcast ring buffer with overwrite.
module tb_broadcast_ring_buffer_overwrite;

  localparam int RING_DEPTH = brbo_pkg::BUFFER_DEPTH_DEF;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int NUM_SLOTS  = brbo_pkg::MAX_READERS_DEF;
  localparam int BURST_MAX  = brbo_pkg::MAX_BURST_DEF;

  // Command codes the block does not decode. It takes them and answers nothing.
  localparam logic [2:0] CMD_FIRST_UNUSED = brbo_pkg::CMD_CLOSE + 3'd1;
  localparam logic [2:0] CMD_TOP_CODE     = '1;

  localparam int SETTLE_CYCLES = 80;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  brbo_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  brbo_pkg::rsp_t rsp;

  broadcast_ring_buffer_overwrite DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the ring. It is updated when a request is accepted, and the
  // results that request must produce are appended to ring_results_due. Entry k
  // of that list is the k-th result the block must return.
  // ---------------------------------------------------------------------------
  bit [7:0]  ring_bytes [RING_DEPTH];
  bit [31:0] head_total;
  bit [31:0] reader_pos [NUM_SLOTS];
  bit        reader_on  [NUM_SLOTS];
  bit        writes_enabled = 1'b1;
  brbo_pkg::rsp_t ring_results_due [$];

  int predicted_total = 0;
  int results_checked = 0;
  int error_count     = 0;
  int requests_taken  = 0;
  int bytes_streamed  = 0;
  int overwrite_drags = 0;
  int writes_dropped  = 0;
  int opens_refused   = 0;
  int reads_refused   = 0;

  // Appends one byte at the head. When the slowest open reader is a whole ring
  // behind, every reader that far back is pulled up so the oldest byte is lost.
  function automatic void append_to_ring(input bit [7:0] value);
    bit [31:0] worst;
    bit [31:0] lag;
    int i;
    worst = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (reader_on[i]) begin
        lag = head_total - reader_pos[i];
        if (lag > worst) worst = lag;
      end
    end
    if (worst >= 32'(RING_DEPTH)) begin
      overwrite_drags++;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (reader_on[i] && (head_total - reader_pos[i]) > 32'(RING_DEPTH - 1))
          reader_pos[i] = head_total - 32'(RING_DEPTH) + 32'd1;
      end
    end
    ring_bytes[RING_AW'(head_total % 32'(RING_DEPTH))] = value;
    head_total = head_total + 32'd1;
  endfunction

  // Applies one request to the shadow ring and queues its results. Returns how
  // many results were queued.
  function automatic int predict_ring_results(input brbo_pkg::req_t r);
    bit [31:0] want;
    bit [31:0] unread;
    bit [31:0] start;
    int        n;
    int        k;
    int        i;
    bit        granted;
    brbo_pkg::rsp_t one;
    n   = 0;
    one = '0;
    one.last = 1'b1;
    case (r.command)
      brbo_pkg::CMD_WRITE: begin
        if (writes_enabled) append_to_ring(r.data_byte);
        else writes_dropped++;
        one.status = brbo_pkg::STAT_OK;
        ring_results_due.push_back(one);
        n = 1;
      end
      brbo_pkg::CMD_READ: begin
        want = 32'(r.max_count);
        if (want > 32'(BURST_MAX)) want = 32'(BURST_MAX);
        start  = reader_pos[r.reader_id];
        unread = head_total - start;
        if (!reader_on[r.reader_id]) begin
          reads_refused++;
          one.status = brbo_pkg::STAT_INVALID;
          ring_results_due.push_back(one);
          n = 1;
        end else if (want == 0 || unread == 0) begin
          one.status = brbo_pkg::STAT_EMPTY;
          ring_results_due.push_back(one);
          n = 1;
        end else begin
          n = int'((want < unread) ? want : unread);
          for (k = 0; k < n; k++) begin
            one.out_byte = ring_bytes[RING_AW'((start + 32'(k)) % 32'(RING_DEPTH))];
            one.status   = brbo_pkg::STAT_DATA;
            one.last     = (k == n - 1);
            ring_results_due.push_back(one);
          end
          reader_pos[r.reader_id] = start + 32'(n);
          bytes_streamed += n;
        end
      end
      brbo_pkg::CMD_OPEN: begin
        granted = 1'b0;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!granted && !reader_on[i]) begin
            granted         = 1'b1;
            reader_on[i]    = 1'b1;
            reader_pos[i]   = head_total;
            one.slot_given  = 3'(i);
          end
        end
        if (granted) begin
          one.status = brbo_pkg::STAT_OK;
        end else begin
          one.status = brbo_pkg::STAT_NOSLOT;
          opens_refused++;
        end
        ring_results_due.push_back(one);
        n = 1;
      end
      brbo_pkg::CMD_RELEASE: begin
        reader_on[r.reader_id] = 1'b0;
        one.status = brbo_pkg::STAT_OK;
        ring_results_due.push_back(one);
        n = 1;
      end
      brbo_pkg::CMD_CLOSE: begin
        writes_enabled = 1'b0;
        one.status = brbo_pkg::STAT_OK;
        ring_results_due.push_back(one);
        n = 1;
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Each backlog entry may ask to wait until every result owed
  // so far has come back, and may ask to skip the random idle gap after it.
  // ---------------------------------------------------------------------------
  typedef struct {
    brbo_pkg::req_t body;
    bit             drain_first;
    bit             steady;
  } backlog_entry_t;

  backlog_entry_t request_backlog [$];
  int idle_left = 0;
  bit took_now;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
      idle_left <= 0;
    end else begin
      took_now = req_valid && req_ready;
      if (took_now) begin
        predicted_total <= predicted_total + predict_ring_results(req);
        requests_taken++;
      end
      // A new request may go out only once the current one has been taken.
      if (!req_valid || took_now) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
          req_valid <= 1'b0;
        end else if (request_backlog.size() != 0 &&
                     (!request_backlog[0].drain_first ||
                      (!took_now && predicted_total == results_checked))) begin
          req       <= request_backlog[0].body;
          req_valid <= 1'b1;
          idle_left <= request_backlog[0].steady ? 0 : pick_gap();
          void'(request_backlog.pop_front());
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Ready stalls at random, with occasional long stretches in
  // which it stays high. Only results owed before this edge are compared.
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  int   quiet_left = 0;
  brbo_pkg::rsp_t due;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (results_checked >= predicted_total) begin
          report_mismatch($sformatf("result with nothing owed: byte %0d status %0d last %0d",
                                    rsp.out_byte, rsp.status, rsp.last));
        end else begin
          due = ring_results_due[results_checked];
          if (rsp.out_byte !== due.out_byte)
            report_mismatch($sformatf("result %0d out_byte %0d, expected %0d",
                                      results_checked, rsp.out_byte, due.out_byte));
          if (rsp.status !== due.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_checked, rsp.status, due.status));
          if (rsp.slot_given !== due.slot_given)
            report_mismatch($sformatf("result %0d slot_given %0d, expected %0d",
                                      results_checked, rsp.slot_given, due.slot_given));
          if (rsp.last !== due.last)
            report_mismatch($sformatf("result %0d last %0d, expected %0d",
                                      results_checked, rsp.last, due.last));
          results_checked <= results_checked + 1;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready  <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if (quiet_left != 0)
          quiet_left <= quiet_left - 1;
        else if ($urandom_range(0, 199) == 0)
          quiet_left <= 150;
        else if ($urandom_range(0, 9) < 3)
          stall_left <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. The generator keeps its own view of which slots are open so that
  // most reads target a live reader.
  // ---------------------------------------------------------------------------
  bit gen_on [NUM_SLOTS];
  int counted_items = 0;
  bit next_drain    = 1'b0;
  bit steady_mode   = 1'b0;

  task automatic add_request(input logic [2:0] cmd, input int data, input int id,
                             input int count);
    backlog_entry_t e;
    int i;
    bit done;
    e.body.command   = cmd;
    e.body.data_byte = 8'(data);
    e.body.reader_id = 3'(id);
    e.body.max_count = 5'(count);
    e.drain_first    = next_drain;
    e.steady         = steady_mode;
    next_drain       = 1'b0;
    if (cmd == brbo_pkg::CMD_OPEN) begin
      done = 1'b0;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (!done && !gen_on[i]) begin
          gen_on[i] = 1'b1;
          done      = 1'b1;
        end
      end
    end
    if (cmd == brbo_pkg::CMD_RELEASE) gen_on[id] = 1'b0;
    counted_items++;
    request_backlog.push_back(e);
  endtask

  // Random open slot, or -1 when none is open.
  function automatic int random_live_slot();
    int live [$];
    int i;
    for (i = 0; i < NUM_SLOTS; i++)
      if (gen_on[i]) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Read sizes: mostly within the burst limit, sometimes zero or above it.
  function automatic int read_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(BURST_MAX + 1, 31);
    return $urandom_range(1, BURST_MAX);
  endfunction

  initial begin
    int n;
    int pick;
    int slot;

    // Directed opening: reads and releases of idle slots, an empty reader,
    // byte extremes, a zero-count read, a saturated read, every slot taken,
    // a refused open, a reclaimed slot and the undecoded command codes.
    add_request(brbo_pkg::CMD_READ, 0, 0, 1);
    add_request(brbo_pkg::CMD_RELEASE, 0, 7, 0);
    add_request(brbo_pkg::CMD_OPEN, 0, 0, 0);
    add_request(brbo_pkg::CMD_READ, 0, 0, 5);
    add_request(brbo_pkg::CMD_WRITE, 'h00, 0, 0);
    add_request(brbo_pkg::CMD_WRITE, 'hFF, 7, 31);
    add_request(brbo_pkg::CMD_WRITE, 'hA5, 5, 21);
    add_request(brbo_pkg::CMD_WRITE, 'h5A, 2, 10);
    add_request(brbo_pkg::CMD_WRITE, 'h01, 0, 0);
    add_request(brbo_pkg::CMD_READ, 0, 0, 0);
    add_request(brbo_pkg::CMD_READ, 'hFF, 0, 2);
    add_request(brbo_pkg::CMD_READ, 0, 0, 31);
    repeat (NUM_SLOTS - 1) add_request(brbo_pkg::CMD_OPEN, 0, 0, 0);
    add_request(brbo_pkg::CMD_OPEN, 0, 0, 0);
    add_request(brbo_pkg::CMD_RELEASE, 0, 3, 0);
    add_request(brbo_pkg::CMD_OPEN, 0, 0, 0);
    add_request(CMD_FIRST_UNUSED, 'hFF, 7, 31);
    add_request(CMD_FIRST_UNUSED + 3'd1, 0, 0, 0);
    add_request(CMD_TOP_CODE, 'h55, 5, 21);

    // Random traffic, mostly writes followed by reads of live readers, with
    // opens, releases, reads of possibly idle slots and undecoded codes mixed in.
    while (counted_items < 320) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) next_drain = 1'b1;
      if ($urandom_range(0, 29) == 0) steady_mode = !steady_mode;
      if (pick < 35) begin
        n = $urandom_range(1, 20);
        repeat (n) add_request(brbo_pkg::CMD_WRITE, $urandom_range(0, 255),
                               $urandom_range(0, 7), $urandom_range(0, 31));
      end else if (pick < 65) begin
        slot = random_live_slot();
        if (slot < 0)
          add_request(brbo_pkg::CMD_OPEN, $urandom_range(0, 255), $urandom_range(0, 7), 0);
        else add_request(brbo_pkg::CMD_READ, $urandom_range(0, 255), slot, read_size());
      end else if (pick < 75) begin
        add_request(brbo_pkg::CMD_OPEN, $urandom_range(0, 255), $urandom_range(0, 7),
                    $urandom_range(0, 31));
      end else if (pick < 83) begin
        add_request(brbo_pkg::CMD_RELEASE, $urandom_range(0, 255), $urandom_range(0, 7),
                    $urandom_range(0, 31));
      end else if (pick < 93) begin
        add_request(brbo_pkg::CMD_READ, $urandom_range(0, 255), $urandom_range(0, 7),
                    $urandom_range(0, 31));
      end else begin
        add_request(3'($urandom_range(32'(CMD_FIRST_UNUSED), 32'(CMD_TOP_CODE))),
                    $urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 31));
      end
    end
    steady_mode = 1'b0;

    // Close once every result so far is in: later writes are dropped but still
    // answered, an open is still granted, and a second close changes nothing.
    next_drain = 1'b1;
    add_request(brbo_pkg::CMD_CLOSE, 0, 0, 0);
    add_request(brbo_pkg::CMD_WRITE, 'h3C, 0, 0);
    add_request(brbo_pkg::CMD_READ, 0, 2, BURST_MAX);
    add_request(brbo_pkg::CMD_OPEN, 0, 0, 0);
    add_request(brbo_pkg::CMD_CLOSE, 'hFF, 7, 31);
    add_request(brbo_pkg::CMD_WRITE, 'hC3, 0, 0);
    add_request(brbo_pkg::CMD_READ, 0, 2, BURST_MAX);
    add_request(brbo_pkg::CMD_RELEASE, 0, 3, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge so no value races the clocked blocks.
    while (request_backlog.size() != 0 || req_valid) @(negedge clk);
    while (results_checked != predicted_total) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (results_checked != predicted_total)
      report_mismatch($sformatf("%0d results never arrived", predicted_total - results_checked));

    $display("Checked %0d results from %0d requests; reads streamed %0d bytes.",
             results_checked, requests_taken, bytes_streamed);
    $display("Overwrite drags %0d, refused opens %0d, refused reads %0d, %s %0d.",
             overwrite_drags, opens_refused, reads_refused,
             "writes dropped after close", writes_dropped);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, set far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/brbo_pkg.sv
rtl/core/brbo_front.sv
rtl/core/brbo_queue.sv
rtl/core/brbo_back.sv
rtl/core/broadcast_ring_buffer_overwrite.sv
sim/tb_broadcast_ring_buffer_overwrite.sv
